// File: rtl/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package bfa_pkg;

   // Frame geometry and field widths.
   localparam int FRAME_BYTES = 4096;
   localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
   localparam int ADDR_W      = 24;
   localparam int BYTES_W     = 25;
   localparam int ACTION_W    = 2;
   localparam int CFG_W       = 13;
   localparam int CSR_IDX_W   = 2;

   // Register reset values.
   localparam int FRAME_TOTAL_RESET = 4096;
   localparam int RESERVED_RESET    = 512;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_TOTAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RESERVED_COUNT = 2'd1;

   // Request kinds.
   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_INIT  = 2'd2
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_load;
      logic clear_start;
      logic clear_step;
      logic scan_start;
      logic scan_step;
      logic scan_latch;
      logic alloc_commit;
      logic free_div;
      logic free_read;
      logic free_write;
      logic rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_alloc;
      logic is_free;
      logic is_init;
      logic free_in_range;
      logic scan_stop;
      logic sweep_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

// File: rtl/bfa_req_if.sv
// Request channel of the bitmap frame allocator: handshake plus request payload.
// Depends on bfa_pkg for the field widths.
interface bfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bfa_pkg::ACTION_W-1:0] action;
   logic [bfa_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, output action, output free_address, input ready);
   modport sink   (input valid, input action, input free_address, output ready);
endinterface

// File: rtl/bfa_rsp_if.sv
// Response channel of the bitmap frame allocator: handshake plus result payload.
// Depends on bfa_pkg for the field widths.
interface bfa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bfa_pkg::ADDR_W-1:0]  alloc_address;
   logic                        out_of_memory;
   logic [bfa_pkg::BYTES_W-1:0] total_bytes;
   logic [bfa_pkg::BYTES_W-1:0] free_bytes;

   modport source (output valid, output alloc_address, output out_of_memory,
                   output total_bytes, output free_bytes, input ready);
   modport sink   (input valid, input alloc_address, input out_of_memory,
                   input total_bytes, input free_bytes, output ready);
endinterface

// File: rtl/bfa_csr_if.sv
// Configuration write channel of the bitmap frame allocator.
// Depends on bfa_pkg for the index and data widths.
interface bfa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::CSR_IDX_W-1:0] index;
   logic [bfa_pkg::CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bfa_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered: the data follows the address in the next cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
// Depends on bfa_pkg for the command and status structs.
module bfa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bfa_pkg::ctrl_status_type status,
   output bfa_pkg::ctrl_cmd_type    cmd
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      ST_BOOT,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_ALLOC_END,
      ST_FREE_READ,
      ST_FREE_WRITE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and the commands issued in each state.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_BOOT: begin
            // Clearing pass after reset; no request is taken meanwhile.
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_alloc) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (status.is_free && status.free_in_range) begin
               cmd.free_div = 1'b1;
               state_in     = ST_FREE_READ;
            end else if (status.is_init) begin
               cmd.clear_start = 1'b1;
               state_in        = ST_CLEAR;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            // One map word per cycle until a word with a clear bit or the end.
            if (status.scan_stop) begin
               cmd.scan_latch = 1'b1;
               state_in       = ST_ALLOC_END;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_ALLOC_END: begin
            cmd.alloc_commit = 1'b1;
            state_in         = ST_RESP;
         end
         ST_FREE_READ: begin
            cmd.free_read = 1'b1;
            state_in      = ST_FREE_WRITE;
         end
         ST_FREE_WRITE: begin
            cmd.free_write = 1'b1;
            state_in       = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/bfa_datapath.sv
// Datapath of the bitmap frame allocator: configuration registers, usage map RAM,
// word scan, free index split, used count and the response register.
// Depends on bfa_pkg, bfa_ram and the channel interfaces.
module bfa_datapath #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bfa_pkg::ctrl_cmd_type            cmd,
   output bfa_pkg::ctrl_status_type         status,
   input  logic [bfa_pkg::ACTION_W-1:0]     req_action,
   input  logic [bfa_pkg::ADDR_W-1:0]       req_free_address,
   bfa_csr_if.sink                          csr,
   bfa_rsp_if.source                        rsp
);
   import bfa_pkg::*;

   localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WI_W       = $clog2(MAP_WORDS + 1);
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int BASE_W     = $clog2((MAP_WORDS + 1) * WORD_BITS + 1);
   localparam int CMP_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;
   localparam int FIDX_W     = ADDR_W - FRAME_SHIFT;
   localparam int FCMP_W     = (FIDX_W > CNT_W) ? FIDX_W : CNT_W;
   localparam int DIV_SH     = FIDX_W + BIT_W;
   localparam int RECIP      = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = FIDX_W + RECIP_W;
   localparam int AX_W       = (BASE_W + FRAME_SHIFT > ADDR_W) ? BASE_W + FRAME_SHIFT : ADDR_W;
   localparam int BX_W       = (CNT_W + FRAME_SHIFT > BYTES_W) ? CNT_W + FRAME_SHIFT : BYTES_W;
   localparam int RESET_USED = (RESERVED_RESET > MAX_FRAMES) ? MAX_FRAMES : RESERVED_RESET;

   // Configuration and control state.
   logic [CFG_W-1:0]     frame_total_ff;
   logic [CFG_W-1:0]     reserved_count_ff;
   logic [CNT_W-1:0]     used_count_ff;
   logic [CNT_W-1:0]     fill_ff;
   logic [WI_W-1:0]      hint_ff;
   logic [BASE_W-1:0]    hint_base_ff;
   logic [WI_W-1:0]      w_ff;
   logic [BASE_W-1:0]    base_ff;
   logic                 rsp_valid_ff;

   // Payload registers.
   logic [ACTION_W-1:0]  req_action_ff;
   logic [FIDX_W-1:0]    req_fidx_ff;
   logic [FIDX_W-1:0]    quot_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic                 hit_ff;
   logic [ADDR_W-1:0]    res_addr_ff;
   logic                 res_oom_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic                 rsp_oom_ff;
   logic [BYTES_W-1:0]   rsp_total_ff;
   logic [BYTES_W-1:0]   rsp_free_ff;

   // Combinational signals.
   logic [CNT_W-1:0]     live_total;
   logic [CNT_W-1:0]     reserved_clamped;
   logic [BASE_W-1:0]    total_base;
   logic [WI_W-1:0]      w_next;
   logic [BASE_W-1:0]    base_next;
   logic [WORD_BITS-1:0] rd_data;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic                 word_full;
   logic [BIT_W-1:0]     first_clear;
   logic [WORD_BITS-1:0] bit_mask;
   logic [BASE_W-1:0]    alloc_frame;
   logic                 alloc_ok;
   logic [AX_W-1:0]      alloc_wide;
   logic [PROD_W-1:0]    quot_prod;
   logic [BASE_W-1:0]    quot_base;
   logic [BIT_W-1:0]     quot_bit;
   logic [BASE_W-1:0]    fill_base;
   logic [BIT_W-1:0]     fill_bits;
   logic [WORD_BITS-1:0] fill_word;
   logic [BX_W-1:0]      total_wide;
   logic [BX_W-1:0]      free_wide;
   logic                 csr_write;

   // Position of the lowest clear bit in a word (zero for a full word).
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   // Live frame total and init reservation, both bounded by the map size.
   always_comb begin
      if (CMP_W'(frame_total_ff) > CMP_W'(MAX_FRAMES)) begin
         live_total = CNT_W'(MAX_FRAMES);
      end else begin
         live_total = CNT_W'(frame_total_ff);
      end
      if (CMP_W'(reserved_count_ff) > CMP_W'(MAX_FRAMES)) begin
         reserved_clamped = CNT_W'(MAX_FRAMES);
      end else begin
         reserved_clamped = CNT_W'(reserved_count_ff);
      end
   end

   assign total_base = BASE_W'(live_total);
   assign w_next     = w_ff + 1'b1;
   assign base_next  = base_ff + BASE_W'(WORD_BITS);

   // Scan evaluation on the word just read.
   assign word_full   = &rd_data;
   assign first_clear = lowest_clear(rd_data);
   assign bit_mask    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_ff;
   assign alloc_frame = base_ff + BASE_W'(bit_ff);
   assign alloc_ok    = hit_ff && (alloc_frame < total_base);
   assign alloc_wide  = AX_W'(alloc_frame) << FRAME_SHIFT;

   // Free: word index by reciprocal multiply, bit index by remainder.
   assign quot_prod = PROD_W'(req_fidx_ff) * PROD_W'(RECIP);
   assign quot_base = BASE_W'(quot_ff) * BASE_W'(WORD_BITS);
   assign quot_bit  = BIT_W'(BASE_W'(req_fidx_ff) - quot_base);

   // Init pattern of the word at base_ff: the reserved frames set.
   assign fill_base = BASE_W'(fill_ff);
   assign fill_bits = BIT_W'(fill_base - base_ff);
   always_comb begin
      if (fill_base >= base_next) begin
         fill_word = '1;
      end else if (fill_base <= base_ff) begin
         fill_word = '0;
      end else begin
         fill_word = ~({WORD_BITS{1'b1}} << fill_bits);
      end
   end

   // RAM port selection.
   always_comb begin
      if (cmd.scan_start) begin
         rd_addr = hint_ff[AW-1:0];
      end else if (cmd.free_read) begin
         rd_addr = AW'(quot_ff);
      end else begin
         rd_addr = w_next[AW-1:0];
      end
      wr_en   = 1'b0;
      wr_data = fill_word;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_commit && alloc_ok) begin
         wr_en   = 1'b1;
         wr_data = word_ff | bit_mask;
      end else if (cmd.free_write) begin
         wr_en   = 1'b1;
         wr_data = rd_data & ~bit_mask;
      end
   end

   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (w_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status toward the controller.
   always_comb begin
      status = '0;
      case (action_type'(req_action_ff))
         ACT_ALLOC: status.is_alloc = 1'b1;
         ACT_FREE:  status.is_free  = 1'b1;
         ACT_INIT:  status.is_init  = 1'b1;
         default:   status.is_alloc = 1'b0;
      endcase
      status.free_in_range = FCMP_W'(req_fidx_ff) < FCMP_W'(live_total);
      status.scan_stop     = !word_full || (base_ff >= total_base);
      status.sweep_last    = (w_ff == WI_W'(MAP_WORDS - 1));
      status.rsp_free      = !rsp_valid_ff || rsp.ready;
   end

   // Configuration writes are taken on every beat.
   assign csr.ready = 1'b1;
   assign csr_write = csr.valid;

   // Control state: registers, counters, hint and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_total_ff    <= CFG_W'(FRAME_TOTAL_RESET);
         reserved_count_ff <= CFG_W'(RESERVED_RESET);
         used_count_ff     <= CNT_W'(RESET_USED);
         fill_ff           <= CNT_W'(RESET_USED);
         hint_ff           <= '0;
         hint_base_ff      <= '0;
         w_ff              <= '0;
         base_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr.index)
               REG_FRAME_TOTAL:    frame_total_ff    <= csr.data;
               REG_RESERVED_COUNT: reserved_count_ff <= csr.data;
               default:            frame_total_ff    <= frame_total_ff;
            endcase
         end
         if (cmd.clear_start) begin
            fill_ff       <= reserved_clamped;
            used_count_ff <= reserved_clamped;
            hint_ff       <= '0;
            hint_base_ff  <= '0;
            w_ff          <= '0;
            base_ff       <= '0;
         end
         if (cmd.clear_step || cmd.scan_step) begin
            w_ff    <= w_next;
            base_ff <= base_next;
         end
         if (cmd.scan_start) begin
            w_ff    <= hint_ff;
            base_ff <= hint_base_ff;
         end
         // Words below the hint are known to be full.
         if (cmd.alloc_commit && alloc_ok) begin
            used_count_ff <= used_count_ff + 1'b1;
            hint_ff       <= w_ff;
            hint_base_ff  <= base_ff;
         end
         if (cmd.free_read) begin
            w_ff    <= WI_W'(quot_ff);
            base_ff <= quot_base;
         end
         if (cmd.free_write) begin
            if (used_count_ff != '0) begin
               used_count_ff <= used_count_ff - 1'b1;
            end
            if (w_ff < hint_ff) begin
               hint_ff      <= w_ff;
               hint_base_ff <= base_ff;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Byte reports from the live total and the updated used count.
   assign total_wide = BX_W'(live_total) << FRAME_SHIFT;
   assign free_wide  = BX_W'(live_total - used_count_ff) << FRAME_SHIFT;

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_action_ff <= req_action;
         req_fidx_ff   <= req_free_address[ADDR_W-1:FRAME_SHIFT];
         res_addr_ff   <= '0;
         res_oom_ff    <= 1'b0;
      end
      if (cmd.free_div) begin
         quot_ff <= FIDX_W'(quot_prod >> DIV_SH);
      end
      if (cmd.scan_latch) begin
         word_ff <= rd_data;
         bit_ff  <= first_clear;
         hit_ff  <= base_ff < total_base;
      end
      if (cmd.free_read) begin
         bit_ff <= quot_bit;
      end
      if (cmd.alloc_commit) begin
         if (alloc_ok) begin
            res_addr_ff <= alloc_wide[ADDR_W-1:0];
         end else begin
            res_oom_ff <= 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         rsp_addr_ff  <= res_addr_ff;
         rsp_oom_ff   <= res_oom_ff;
         rsp_total_ff <= total_wide[BYTES_W-1:0];
         if (live_total > used_count_ff) begin
            rsp_free_ff <= free_wide[BYTES_W-1:0];
         end else begin
            rsp_free_ff <= '0;
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.alloc_address = rsp_addr_ff;
   assign rsp.out_of_memory = rsp_oom_ff;
   assign rsp.total_bytes   = rsp_total_ff;
   assign rsp.free_bytes    = rsp_free_ff;

   // A successful allocation raises the used count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_commit && alloc_ok) |=> used_count_ff == $past(used_count_ff) + 1'b1)
      else $error("used count not raised after a successful allocation");

   // The scan never advances past a word that starts at or above the live total.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> base_ff < total_base)
      else $error("scan stepped beyond the frame total");

   // A failed allocation reports address zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oom_ff) |-> rsp_addr_ff == '0)
      else $error("out-of-memory result with a nonzero address");

   // A free writes back the word that holds the freed frame.
   assert property (@(posedge clock) disable iff (reset)
      cmd.free_write |-> w_ff == WI_W'(quot_ff))
      else $error("free wrote a word other than the frame's word");

endmodule

// File: rtl/bitmap_frame_allocator.sv
// Bitmap frame allocator: one usage bit per 4 KiB frame, kept in a RAM of
// WORD_BITS-wide words, plus a count of used frames. It works on one request at a
// time; the response register lets the next request beat in while a result waits.
// An allocate reads map words, one per cycle, starting at the lowest word that may
// still hold a clear frame; after the first allocation following an init this is
// usually one word. A free of a frame beyond the frame total leaves the map as it
// is, and an init rewrites every map word. After reset the block runs the same
// clearing pass before it takes its first request; configuration writes are taken
// throughout.
// Depends on bfa_pkg, the channel interfaces, bfa_ctrl and bfa_datapath.
module bitmap_frame_allocator #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic      clock,
   input  logic      reset,
   bfa_req_if.sink   req_bus,
   bfa_rsp_if.source rsp_bus,
   bfa_csr_if.sink   csr_bus
);
   import bfa_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer of each request.
   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Map storage, counters and result formatting.
   bfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_bus.action),
      .req_free_address (req_bus.free_address),
      .csr              (csr_bus),
      .rsp              (rsp_bus)
   );

endmodule

// File: tb/sv/bfa_result_checker.sv
// Scoreboard for the bitmap frame allocator. It follows the usage map, the used count
// and both registers from the beats on the three channels, and checks every result.
// Depends on bfa_pkg and the request, response and configuration interfaces.
module bfa_result_checker #(
   parameter int MAX_FRAMES = 4096
) (
   input  logic clock,
   input  logic reset,
   bfa_req_if   req_bus,
   bfa_rsp_if   rsp_bus,
   bfa_csr_if   csr_bus,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bfa_pkg::*;

   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [ADDR_W-1:0]  alloc_address;
      logic               out_of_memory;
      logic [BYTES_W-1:0] total_bytes;
      logic [BYTES_W-1:0] free_bytes;
   } frame_result_type;

   // Shadow copy of the allocator state and its registers.
   bit               frame_used [MAX_FRAMES];
   int unsigned      busy_count;
   logic [CFG_W-1:0] total_reg;
   logic [CFG_W-1:0] reserved_reg;
   frame_result_type expected_results [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // One line per mismatch; the count goes on after the printing stops.
   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t ns result check: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Clears the map and marks the reserved low frames used, clamped to the map size.
   function automatic void load_reservation();
      int unsigned count;
      count = (reserved_reg > MAX_FRAMES) ? MAX_FRAMES : reserved_reg;
      for (int f = 0; f < MAX_FRAMES; f++) begin
         frame_used[f] = (f < count);
      end
      busy_count = count;
   endfunction

   // Applies one request to the shadow state and returns the result it must produce.
   function automatic frame_result_type serve_request(input logic [ACTION_W-1:0] act,
                                                      input logic [ADDR_W-1:0]   addr);
      frame_result_type res;
      int unsigned      live;
      int unsigned      frame;
      bit               found;
      res   = '0;
      found = 1'b0;
      frame = 0;
      // The frame total is read live on every request and clamped to the map size.
      live  = (total_reg > MAX_FRAMES) ? MAX_FRAMES : total_reg;
      case (act)
         ACT_ALLOC: begin
            for (int f = 0; f < live && !found; f++) begin
               if (!frame_used[f]) begin
                  found = 1'b1;
                  frame = f;
               end
            end
            if (found) begin
               frame_used[frame] = 1'b1;
               busy_count++;
               res.alloc_address = ADDR_W'(frame * FRAME_BYTES);
            end else begin
               res.out_of_memory = 1'b1;
            end
         end
         ACT_FREE: begin
            // Frames at or beyond the total are ignored; a clear frame still drops the count.
            frame = addr >> FRAME_SHIFT;
            if (frame < live) begin
               frame_used[frame] = 1'b0;
               if (busy_count != 0) begin
                  busy_count--;
               end
            end
         end
         ACT_INIT: begin
            load_reservation();
         end
         default: begin
         end
      endcase
      res.total_bytes = BYTES_W'(live * FRAME_BYTES);
      res.free_bytes  = (live > busy_count) ? BYTES_W'((live - busy_count) * FRAME_BYTES)
                                            : '0;
      return res;
   endfunction

   // Compares a result beat with the oldest outstanding expectation.
   task automatic check_result();
      frame_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result beat with no request outstanding");
      end else begin
         want = expected_results.pop_front();
         if (rsp_bus.alloc_address !== want.alloc_address) begin
            report_mismatch($sformatf("alloc_address expected 0x%06h, got 0x%06h",
                                      want.alloc_address, rsp_bus.alloc_address));
         end
         if (rsp_bus.out_of_memory !== want.out_of_memory) begin
            report_mismatch($sformatf("out_of_memory expected %0b, got %0b",
                                      want.out_of_memory, rsp_bus.out_of_memory));
         end
         if (rsp_bus.total_bytes !== want.total_bytes) begin
            report_mismatch($sformatf("total_bytes expected 0x%07h, got 0x%07h",
                                      want.total_bytes, rsp_bus.total_bytes));
         end
         if (rsp_bus.free_bytes !== want.free_bytes) begin
            report_mismatch($sformatf("free_bytes expected 0x%07h, got 0x%07h",
                                      want.free_bytes, rsp_bus.free_bytes));
         end
      end
   endtask

   // Watch all three channels on every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         total_reg    = CFG_W'(FRAME_TOTAL_RESET);
         reserved_reg = CFG_W'(RESERVED_RESET);
         load_reservation();
         expected_results.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_FRAME_TOTAL:    total_reg    = csr_bus.data;
               REG_RESERVED_COUNT: reserved_reg = csr_bus.data;
               default: begin
               end
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(serve_request(req_bus.action, req_bus.free_address));
         end
      end
      pending <= expected_results.size();
   end

endmodule

// File: tb/sv/tb_bitmap_frame_allocator.sv
// Top of the bitmap frame allocator testbench: clock, reset, request and register
// stimulus, response back-pressure and the verdict. Depends on bfa_pkg, the channel
// interfaces, bitmap_frame_allocator and bfa_result_checker.
module tb_bitmap_frame_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import bfa_pkg::*;

   localparam int MAX_FRAMES   = 4096;
   localparam int CFG_MAX      = (1 << CFG_W) - 1;
   localparam int FIDX_W       = ADDR_W - FRAME_SHIFT;
   localparam int RESET_CYCLES = 12;
   localparam int ITEM_GOAL    = 1350;
   localparam int STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 1000000;

   // The action code that the package leaves unnamed.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_hold = 1'b0;
   int   fail_count;
   int   pending;
   int   items_sent = 0;
   int   send_idle_pct = 19;
   int   recv_idle_pct = 63;
   int   stall_asks = 0;

   bfa_req_if req_bus ();
   bfa_rsp_if rsp_bus ();
   bfa_csr_if csr_bus ();

   bitmap_frame_allocator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bfa_result_checker #(.MAX_FRAMES(MAX_FRAMES)) result_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 10 ns clock.
   always #5 clock = ~clock;

   // Offers one request beat after a random number of idle cycles. Valid stays high
   // after the beat so that back-to-back beats need no extra edge.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [ADDR_W-1:0]   addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.free_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Waits until every result is back, then writes both registers.
   task automatic configure(input int unsigned total, input int unsigned reserved);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= REG_FRAME_TOTAL;
      csr_bus.data  <= CFG_W'(total);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= REG_RESERVED_COUNT;
      csr_bus.data  <= CFG_W'(reserved);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // One random stretch: a fresh setting, an init, then a mix of requests.
   task automatic run_segment(input bit with_stall);
      int unsigned total;
      int unsigned reserved;
      int unsigned live;
      int unsigned count;
      int unsigned pick;
      int unsigned frame;
      logic [ADDR_W-1:0] addr;
      // Mostly small totals so that the map fills up and allocations fail.
      pick = $urandom_range(99);
      if (pick < 70)      total = $urandom_range(160, 1);
      else if (pick < 78) total = $urandom_range(CFG_MAX, 0);
      else if (pick < 84) total = 0;
      else if (pick < 92) total = MAX_FRAMES;
      else                total = CFG_MAX;
      live = (total > MAX_FRAMES) ? MAX_FRAMES : total;
      pick = $urandom_range(99);
      if (pick < 65)      reserved = $urandom_range(live, 0);
      else if (pick < 80) reserved = 0;
      else                reserved = $urandom_range(CFG_MAX, 0);
      configure(total, reserved);
      send_request(ACT_INIT, ADDR_W'($urandom));
      // The long response stall starts while requests keep coming.
      if (with_stall) begin
         stall_asks <= stall_asks + 1;
      end
      count = with_stall ? 60 : $urandom_range(120, 20);
      repeat (count) begin
         pick = $urandom_range(99);
         addr = ADDR_W'($urandom);
         if (pick < 48) begin
            send_request(ACT_ALLOC, addr);
         end else if (pick < 88) begin
            // Mostly frames inside the total, some just past it, some anywhere.
            if (pick < 78 && live != 0) begin
               frame = $urandom_range(live - 1, 0);
               addr[ADDR_W-1:FRAME_SHIFT] = FIDX_W'(frame);
            end else if (pick < 84) begin
               addr[ADDR_W-1:FRAME_SHIFT] = FIDX_W'(live);
            end
            send_request(ACT_FREE, addr);
         end else if (pick < 94) begin
            send_request(ACT_INIT, addr);
         end else begin
            send_request(ACT_UNUSED, addr);
         end
      end
   endtask

   // Response ready: random idling plus the long hold-off.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Counts out the long response hold-off each time one is asked for.
   initial begin : stall_control
      int served;
      int held;
      served = 0;
      forever begin
         @(posedge clock);
         if (stall_asks != served) begin
            served++;
            rsp_hold <= 1'b1;
            held = 0;
            while (held < STALL_CYCLES) begin
               @(posedge clock);
               held++;
            end
            rsp_hold <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_bitmap_frame_allocator: FAIL");
      $finish;
   end

   // Main stimulus and verdict.
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_ALLOC;
      req_bus.free_address = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = REG_FRAME_TOTAL;
      csr_bus.data         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The block clears its map after reset before it takes requests.
      do @(posedge clock); while (!req_bus.ready);

      // Reset setting: allocate above the reservation, free with offset bits set,
      // free a frame that is already clear, and the unused action.
      send_request(ACT_ALLOC, '0);
      send_request(ACT_ALLOC, '1);
      send_request(ACT_FREE, 24'h200FFF);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 24'hFFFFFF);
      send_request(ACT_UNUSED, 24'hABCDEF);

      // Empty allocator: allocation fails and every free lies beyond the total.
      configure(0, 0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, '0);
      send_request(ACT_INIT, '0);

      // Both registers at their maximum: the reservation clamps to the map size.
      configure(CFG_MAX, CFG_MAX);
      send_request(ACT_INIT, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 24'h000000);
      send_request(ACT_ALLOC, '1);

      // No reservation: the count must stay at zero on a second free.
      configure(MAX_FRAMES, 0);
      send_request(ACT_INIT, '1);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 24'h000000);
      send_request(ACT_FREE, 24'h000000);

      // Reservation above the total: free bytes read zero; free past the total.
      configure(40, MAX_FRAMES);
      send_request(ACT_INIT, '0);
      send_request(ACT_FREE, 24'h027000);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 24'h028000);
      send_request(ACT_ALLOC, '0);

      // The total is read live: lowering it without an init still leaves frame 32 inside it.
      configure(33, 0);
      send_request(ACT_FREE, 24'h020000);
      send_request(ACT_ALLOC, '0);

      // Random part in three idling phases; the first stretch carries the long stall.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 63 : 0;
         recv_idle_pct <= (ph == 0) ? 63 : (ph == 1) ? 19 : 0;
         while (items_sent < ITEM_GOAL * (ph + 1) / 3) begin
            run_segment(ph == 0 && stall_asks == 0);
         end
      end

      // Let every result come back, then watch a while for stray beats.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_bitmap_frame_allocator: PASS");
      end else begin
         $display("tb_bitmap_frame_allocator: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/bfa_pkg.sv
rtl/bfa_req_if.sv
rtl/bfa_rsp_if.sv
rtl/bfa_csr_if.sv
rtl/bfa_ram.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_frame_allocator.sv
tb/sv/bfa_result_checker.sv
tb/sv/tb_bitmap_frame_allocator.sv
